@@ src/csv_field_splitter_top_macros.svh @@
// Assertion macros used by the checker file of the splitter.
`ifndef CSV_FIELD_SPLITTER_TOP_MACROS_SVH
`define CSV_FIELD_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CSVFS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("csv splitter check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CSVFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("csv splitter check failed");

`endif

@@ src/csvfs_pkg.sv @@
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the text line cell splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    // Depth of the held whitespace buffer.
    localparam int SPACE_DEPTH = 16;
    // Count width holds 0 .. SPACE_DEPTH; index width addresses the buffer.
    localparam int CNT_W = $clog2(SPACE_DEPTH + 1);
    localparam int IDX_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'h2C;
    localparam logic [7:0] WS_SPACE = 8'h20;
    localparam logic [7:0] WS_TAB = 8'h09;
    localparam logic [7:0] WS_CR = 8'h0D;
    localparam logic [7:0] WS_LF = 8'h0A;

    // Operation carried from the front to the back.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_HOLD  = 2'd1,
        OP_EMIT  = 2'd2,
        OP_CLOSE = 2'd3
    } t_op;

    // One queued command: the byte action of an item plus its line end.
    typedef struct packed {
        t_op              op;
        logic [7:0]       data;
        logic [CNT_W-1:0] cnt;
        logic             ov;
        logic             eol;
    } t_cmd;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == WS_SPACE) || (c == WS_TAB) || (c == WS_CR) || (c == WS_LF);
    endfunction

endpackage

@@ src/csvfs_if.sv @@
// ----------------------------------------------------------------------------
// csvfs_in_if / csvfs_out_if
// Valid/ready channels for input items and result items of the splitter.
// ----------------------------------------------------------------------------
interface csvfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_line;

    modport source (output valid, in_byte, byte_present, end_of_line, input ready);
    modport sink (input valid, in_byte, byte_present, end_of_line, output ready);
endinterface

interface csvfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       cell_end;
    logic       line_end;
    logic       run_last;
    logic       space_overflow;

    modport source (output valid, out_byte, has_byte, cell_end, line_end, run_last,
                    space_overflow, input ready);
    modport sink (input valid, out_byte, has_byte, cell_end, line_end, run_last,
                  space_overflow, output ready);
endinterface

@@ src/csvfs_front.sv @@
// ----------------------------------------------------------------------------
// csvfs_front
// Accepts input requests, tracks quote and trim state, and issues commands.
// ----------------------------------------------------------------------------
module csvfs_front
    import csvfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    csvfs_in_if.sink   i_in,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_cmd       o_push_data
);

    logic [7:0]       r_delim;
    logic             r_qm, r_qp, r_started, r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic             n_qm, n_qp, n_started, n_ovf;
    logic [CNT_W-1:0] n_cnt;
    logic             accept;
    logic             do_plain, do_content, do_close;
    t_cmd             cmd;

    assign i_in.ready = i_push_ready;
    assign accept = i_in.valid && i_push_ready;

    // Classify the item and work out the next tokenizer state.
    always_comb begin
        n_qm = r_qm;
        n_qp = r_qp;
        n_started = r_started;
        n_ovf = r_ovf;
        n_cnt = r_cnt;
        do_plain = 1'b0;
        do_content = 1'b0;
        do_close = 1'b0;
        cmd.op = OP_NONE;
        cmd.data = i_in.in_byte;
        cmd.cnt = r_cnt;
        cmd.ov = r_ovf;
        cmd.eol = i_in.end_of_line;

        if (i_in.byte_present) begin
            if (r_qp) begin
                n_qp = 1'b0;
                if (i_in.in_byte == QUOTE_BYTE) begin
                    do_content = 1'b1;
                end else begin
                    n_qm = 1'b0;
                    do_plain = 1'b1;
                end
            end else begin
                do_plain = 1'b1;
            end

            if (do_plain) begin
                if (i_in.in_byte == QUOTE_BYTE) begin
                    if (n_qm) begin
                        n_qp = 1'b1;
                    end else begin
                        n_qm = 1'b1;
                    end
                end else if (i_in.in_byte == r_delim && !n_qm) begin
                    do_close = 1'b1;
                end else begin
                    do_content = 1'b1;
                end
            end

            if (do_content) begin
                if (is_ws(i_in.in_byte)) begin
                    if (r_started) begin
                        if (r_cnt < CNT_W'(SPACE_DEPTH)) begin
                            cmd.op = OP_HOLD;
                            n_cnt = r_cnt + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end else begin
                    cmd.op = OP_EMIT;
                    n_cnt = '0;
                    n_ovf = 1'b0;
                    n_started = 1'b1;
                end
            end

            if (do_close) begin
                cmd.op = OP_CLOSE;
                n_started = 1'b0;
                n_cnt = '0;
                n_ovf = 1'b0;
            end
        end

        // A line end closes the cell and clears all quote state.
        if (i_in.end_of_line) begin
            n_started = 1'b0;
            n_cnt = '0;
            n_ovf = 1'b0;
            n_qm = 1'b0;
            n_qp = 1'b0;
        end
    end

    assign o_push_valid = accept && ((cmd.op != OP_NONE) || i_in.end_of_line);
    assign o_push_data = cmd;

    // State registers and the delimiter register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_qm <= 1'b0;
            r_qp <= 1'b0;
            r_started <= 1'b0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_delim <= i_cfg_data;
            end
            if (accept) begin
                r_qm <= n_qm;
                r_qp <= n_qp;
                r_started <= n_started;
                r_ovf <= n_ovf;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule

@@ src/csvfs_queue.sv @@
// ----------------------------------------------------------------------------
// csvfs_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module csvfs_queue
    import csvfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_data
);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data = r_slot[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop = o_pop_valid && i_pop_ready;

    // Pointer and fill count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push_data;
        end
    end

endmodule

@@ src/csvfs_back.sv @@
// ----------------------------------------------------------------------------
// csvfs_back
// Executes queued commands: holds whitespace and emits one result a cycle while o_out is ready.
// ----------------------------------------------------------------------------
module csvfs_back
    import csvfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_cmd        i_pop_data,
    csvfs_out_if.source o_out
);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_FLUSH = 5'b00010,
        PH_BYTE  = 5'b00100,
        PH_CELL  = 5'b01000,
        PH_LINE  = 5'b10000
    } t_phase;

    logic [7:0]       r_space [SPACE_DEPTH];
    logic [7:0]       r_rdata;
    t_phase           r_phase, ph, n_phase;
    t_cmd             r_cmd, cur;
    logic [CNT_W-1:0] r_idx, idx, n_idx;
    logic             can_load, go, pop;
    logic             res_has, res_ce, res_le, res_last, res_ov, res_mem;
    logic [7:0]       res_byte;

    logic             r_valid, r_has, r_ce, r_le, r_last, r_ov, r_mem;
    logic [7:0]       r_byte;

    assign can_load = !r_valid || o_out.ready;
    assign pop = (r_phase == PH_IDLE) && i_pop_valid && can_load;
    assign o_pop_ready = (r_phase == PH_IDLE) && can_load;

    // Pick the command and phase that this cycle works on.
    always_comb begin
        cur = r_cmd;
        ph = r_phase;
        idx = r_idx;
        if (r_phase == PH_IDLE) begin
            cur = i_pop_data;
            idx = '0;
            if (!i_pop_valid) begin
                ph = PH_IDLE;
            end else begin
                unique case (i_pop_data.op)
                    OP_HOLD:  ph = i_pop_data.eol ? PH_LINE : PH_IDLE;
                    OP_EMIT:  ph = (i_pop_data.cnt != '0) ? PH_FLUSH : PH_BYTE;
                    OP_CLOSE: ph = PH_CELL;
                    default:  ph = PH_LINE;
                endcase
            end
        end
    end

    // One result step of the sequencer.
    always_comb begin
        res_byte = 8'h00;
        res_has = 1'b0;
        res_ce = 1'b0;
        res_le = 1'b0;
        res_last = 1'b0;
        res_ov = 1'b0;
        res_mem = 1'b0;
        n_phase = PH_IDLE;
        n_idx = idx;
        unique case (ph)
            PH_FLUSH: begin
                res_has = 1'b1;
                res_mem = 1'b1;
                n_idx = idx + CNT_W'(1);
                n_phase = (n_idx == cur.cnt) ? PH_BYTE : PH_FLUSH;
            end
            PH_BYTE: begin
                res_byte = cur.data;
                res_has = 1'b1;
                res_ov = cur.ov;
                res_last = !cur.eol;
                n_phase = cur.eol ? PH_LINE : PH_IDLE;
            end
            PH_CELL: begin
                res_ce = 1'b1;
                res_last = !cur.eol;
                n_phase = cur.eol ? PH_LINE : PH_IDLE;
            end
            PH_LINE: begin
                res_ce = 1'b1;
                res_le = 1'b1;
                res_last = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign go = can_load && (ph != PH_IDLE);

    // Sequencer and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (go) begin
                r_phase <= n_phase;
                r_valid <= 1'b1;
            end else begin
                if (pop) begin
                    r_phase <= PH_IDLE;
                end
                if (o_out.ready) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    // Payload registers, command latch and index.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_pop_data;
        end
        if (go) begin
            r_idx <= n_idx;
            r_byte <= res_byte;
            r_has <= res_has;
            r_ce <= res_ce;
            r_le <= res_le;
            r_last <= res_last;
            r_ov <= res_ov;
            r_mem <= res_mem;
        end
    end

    // Whitespace buffer: written by hold commands, read while flushing.
    always_ff @(posedge i_clk) begin
        if (pop && (i_pop_data.op == OP_HOLD)) begin
            r_space[i_pop_data.cnt[IDX_W-1:0]] <= i_pop_data.data;
        end
        if (go && (ph == PH_FLUSH)) begin
            r_rdata <= r_space[idx[IDX_W-1:0]];
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.out_byte = r_mem ? r_rdata : r_byte;
    assign o_out.has_byte = r_has;
    assign o_out.cell_end = r_ce;
    assign o_out.line_end = r_le;
    assign o_out.run_last = r_last;
    assign o_out.space_overflow = r_ov;

endmodule

@@ src/csv_field_splitter_top.sv @@
// ----------------------------------------------------------------------------
// csv_field_splitter_top
// Streaming splitter of one text line into trimmed, unquoted cells.
// ----------------------------------------------------------------------------
// Usage: each request on i_in carries one byte of a line (or a bare end
// marker) and an end-of-line flag. Each request on o_out carries one cell
// byte, a cell-end mark or a line-end mark; run_last flags the final result
// of an input request. i_cfg_we with i_cfg_data sets the delimiter byte,
// which the user writes only while the block is idle; the block itself does
// not enforce this. Flow: an accepted request is written into the command
// queue; the back sequencer pops it and registers its first result for o_out.
// Throughput: one result per cycle out of the back sequencer while o_out is
// ready; held whitespace is read from the buffer one byte per cycle. Requests
// that produce at most one result flow at one per cycle while o_out is ready.
// A two-entry command queue lets input keep flowing while the back end flushes
// or the output waits.
// Reset: the synchronous active-low reset clears the quote and trim state,
// empties the queue and restores the comma delimiter; the whitespace
// buffer is not cleared and needs no clearing pass.
// Stall: when o_out.ready is low the result holds; the queue then fills
// and i_in.ready drops.
// ----------------------------------------------------------------------------
module csv_field_splitter_top
    import csvfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    csvfs_in_if.sink    i_in,
    csvfs_out_if.source o_out
);

    logic push_valid, push_ready, pop_valid, pop_ready;
    t_cmd push_data, pop_data;

    // Front: classification and state tracking.
    csvfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // Command queue between the two halves.
    csvfs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Back: result sequencing and the whitespace buffer.
    csvfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out       (o_out)
    );

endmodule

@@ src/csvfs_checker.sv @@
// ----------------------------------------------------------------------------
// csvfs_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "csv_field_splitter_top_macros.svh"

module csvfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_out_byte,
    input logic       i_has_byte,
    input logic       i_cell_end,
    input logic       i_line_end,
    input logic       i_run_last,
    input logic       i_space_overflow
);

    logic [12:0] payload;
    logic        mark_clean;
    logic        last_mark;

    // Whole result payload, and the shapes that marks must have.
    assign payload = {i_out_byte, i_has_byte, i_cell_end, i_line_end, i_run_last,
                      i_space_overflow};
    assign mark_clean = (i_out_byte == 8'h00) && !i_space_overflow;
    assign last_mark = i_cell_end && i_run_last;

    // A result is either a byte or a mark, never both.
    `CSVFS_ASSERT_NOW(a_byte_or_mark, i_clk, i_rst_n, i_valid && i_has_byte, !i_cell_end)

    // A line end closes a cell and is the last result of its request.
    `CSVFS_ASSERT_NOW(a_line_end, i_clk, i_rst_n, i_valid && i_line_end, last_mark)

    // Marks carry a zero byte and no overflow flag.
    `CSVFS_ASSERT_NOW(a_mark_clean, i_clk, i_rst_n, i_valid && !i_has_byte, mark_clean)

    // A stalled result holds its payload.
    `CSVFS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(payload))

endmodule

bind csv_field_splitter_top csvfs_checker u_csvfs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_has_byte       (o_out.has_byte),
    .i_cell_end       (o_out.cell_end),
    .i_line_end       (o_out.line_end),
    .i_run_last       (o_out.run_last),
    .i_space_overflow (o_out.space_overflow)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text line cell splitter. A directed table walks
// empty and idle requests, byte extremes, trimming and the quote rules. Then
// random lines of quoted and bare cells with long whitespace runs, plus some
// noise, run under a series of delimiter bytes. Every result is compared with
// a built-in predictor of the splitter, while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import csvfs_pkg::*;

    // Kinds of rows in the directed table.
    localparam int ROW_PREDICTED = -1;
    localparam int ROW_SILENT = 0;
    localparam int ROW_ONE = 1;

    localparam int DRAIN_PAD = 8;
    localparam int END_PAD = 20;
    localparam int PHASE_ITEMS = 32;
    localparam int PHASES = 9;

    // One result of the splitter, field by field.
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       ce;
        logic       le;
        logic       last;
        logic       ov;
    } t_token;

    // One directed request with an optional typed result.
    typedef struct {
        logic [7:0] b;
        logic       p;
        logic       e;
        int         kind;
        logic [7:0] xb;
        logic       xh;
        logic       xce;
        logic       xle;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    csvfs_in_if  in_ch();
    csvfs_out_if out_ch();

    csv_field_splitter_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor state of the splitter.
    logic [7:0] delim_q = DELIM_RESET;
    logic       in_quotes = 1'b0;
    logic       quote_wait = 1'b0;
    logic       cell_open = 1'b0;
    logic       spill = 1'b0;
    logic [7:0] held_blanks [SPACE_DEPTH];
    int         held_cnt = 0;

    t_token step_tokens[$];
    t_token expected_tokens[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  lines_closed = 0;
    int  spill_flags = 0;
    int  delim_writes = 0;
    logic feed_steady = 1'b0;
    logic sink_steady = 1'b0;

    // Directed table: empty line, idle request, extremes, trimming, quotes.
    t_row plan [25] = '{
        '{8'h00, 0, 1, ROW_ONE, 8'h00, 0, 1, 1},
        '{8'h00, 0, 0, ROW_SILENT, 8'h00, 0, 0, 0},
        '{8'hFF, 1, 0, ROW_ONE, 8'hFF, 1, 0, 0},
        '{8'h00, 1, 0, ROW_ONE, 8'h00, 1, 0, 0},
        '{WS_SPACE, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{WS_TAB, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{8'h41, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{WS_CR, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{DELIM_RESET, 1, 0, ROW_ONE, 8'h00, 0, 1, 0},
        '{WS_LF, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{QUOTE_BYTE, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{WS_SPACE, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{8'h62, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{QUOTE_BYTE, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{QUOTE_BYTE, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{DELIM_RESET, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{QUOTE_BYTE, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{8'h00, 0, 1, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{QUOTE_BYTE, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{8'h78, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{DELIM_RESET, 1, 1, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{QUOTE_BYTE, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{DELIM_RESET, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{QUOTE_BYTE, 1, 0, ROW_PREDICTED, 8'h00, 0, 0, 0},
        '{8'h7A, 1, 1, ROW_PREDICTED, 8'h00, 0, 0, 0}
    };

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic blank_char(input logic [7:0] c);
        return c == WS_SPACE || c == WS_TAB || c == WS_CR || c == WS_LF;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return WS_SPACE;
            1: return WS_TAB;
            2: return WS_CR;
            default: return WS_LF;
        endcase
    endfunction

    task automatic log_mismatch(input string what, input logic [7:0] want,
                                input logic [7:0] got);
        $display("tb_top: mismatch on %s: expected %h, got %h at %0t",
                 what, want, got, $realtime);
        mismatches++;
    endtask

    task automatic add_token(input logic [7:0] b, input logic has, input logic ce,
                             input logic le, input logic ov);
        t_token t;
        t.data = has ? b : 8'h00;
        t.has = has;
        t.ce = ce;
        t.le = le;
        t.last = 1'b0;
        t.ov = ov;
        step_tokens = {step_tokens, t};
    endtask

    // Ending a cell drops any held trailing whitespace.
    task automatic end_cell(input logic le);
        add_token(8'h00, 1'b0, 1'b1, le, 1'b0);
        cell_open = 1'b0;
        held_cnt = 0;
        spill = 1'b0;
    endtask

    // Whitespace is held until a visible byte arrives, then flushed before it.
    task automatic take_content(input logic [7:0] c);
        if (blank_char(c)) begin
            if (!cell_open)
                return;
            if (held_cnt < SPACE_DEPTH) begin
                held_blanks[held_cnt] = c;
                held_cnt++;
            end else begin
                spill = 1'b1;
            end
            return;
        end
        for (int k = 0; k < held_cnt; k++)
            add_token(held_blanks[k], 1'b1, 1'b0, 1'b0, 1'b0);
        add_token(c, 1'b1, 1'b0, 1'b0, spill);
        held_cnt = 0;
        spill = 1'b0;
        cell_open = 1'b1;
    endtask

    // Quote handling comes first, so a quote delimiter never splits.
    task automatic route_byte(input logic [7:0] c);
        if (c == QUOTE_BYTE) begin
            if (in_quotes)
                quote_wait = 1'b1;
            else
                in_quotes = 1'b1;
        end else if (c == delim_q && !in_quotes) begin
            end_cell(1'b0);
        end else begin
            take_content(c);
        end
    endtask

    // Works out the results of one request into step_tokens.
    task automatic predict_split(input logic [7:0] b, input logic p, input logic e);
        step_tokens.delete();
        if (p) begin
            if (quote_wait) begin
                quote_wait = 1'b0;
                if (b == QUOTE_BYTE) begin
                    take_content(QUOTE_BYTE);
                end else begin
                    in_quotes = 1'b0;
                    route_byte(b);
                end
            end else begin
                route_byte(b);
            end
        end
        if (e) begin
            end_cell(1'b1);
            in_quotes = 1'b0;
            quote_wait = 1'b0;
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
    endtask

    // Drives one request after a random gap and records what it must cause.
    task automatic send_item(input logic [7:0] b, input logic p, input logic e,
                             input int kind = ROW_PREDICTED, input t_token typed = '0);
        int gap;
        if ($urandom_range(0, 19) == 0)
            feed_steady = !feed_steady;
        gap = feed_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.byte_present <= p;
        in_ch.end_of_line <= e;
        do @(negedge i_clk); while (in_ch.ready !== 1'b1);
        @(posedge i_clk);
        predict_split(b, p, e);
        if (kind == ROW_PREDICTED) begin
            foreach (step_tokens[k])
                expected_tokens = {expected_tokens, step_tokens[k]};
        end else if (kind == ROW_ONE) begin
            expected_tokens = {expected_tokens, typed};
        end
        if (p || e)
            items_sent++;
    endtask

    task automatic send_content(input logic quoted);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            send_item(8'h61 + 8'($urandom_range(0, 25)), 1'b1, 1'b0);
        end else if (pick < 12) begin
            send_item(8'($urandom), 1'b1, 1'b0);
        end else if (pick < 15) begin
            repeat ($urandom_range(1, 3)) send_item(pick_blank(), 1'b1, 1'b0);
        end else if (pick == 15) begin
            // Long inner run that may spill past the whitespace buffer.
            repeat ($urandom_range(SPACE_DEPTH - 1, SPACE_DEPTH + 3))
                send_item(pick_blank(), 1'b1, 1'b0);
        end else if (pick < 18 && quoted) begin
            send_item(QUOTE_BYTE, 1'b1, 1'b0);
            send_item(QUOTE_BYTE, 1'b1, 1'b0);
        end else if (quoted) begin
            send_item(delim_q, 1'b1, 1'b0);
        end else begin
            send_item(8'($urandom), 1'b1, 1'b0);
        end
    endtask

    // A well-formed line: padded cells, some quoted, joined by the delimiter.
    task automatic send_line();
        int   cells;
        logic quoted;
        cells = $urandom_range(1, 4);
        for (int k = 0; k < cells; k++) begin
            repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b1, 1'b0);
            quoted = ($urandom_range(0, 2) == 0);
            if (quoted)
                send_item(QUOTE_BYTE, 1'b1, 1'b0);
            repeat ($urandom_range(0, 6)) send_content(quoted);
            if (quoted)
                send_item(QUOTE_BYTE, 1'b1, 1'b0);
            repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b1, 1'b0);
            if (k < cells - 1)
                send_item(delim_q, 1'b1, 1'b0);
        end
        if ($urandom_range(0, 1) == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
        else
            send_item(8'h61 + 8'($urandom_range(0, 25)), 1'b1, 1'b1);
    endtask

    // Writes the delimiter once all results are in and the pipe is empty.
    task automatic set_delimiter(input logic [7:0] value);
        in_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        delim_q = value;
        delim_writes++;
    endtask

    task automatic check_token(input t_token got);
        t_token want;
        results_checked++;
        if (got.le === 1'b1)
            lines_closed++;
        if (got.ov === 1'b1)
            spill_flags++;
        if (expected_tokens.size() == 0) begin
            log_mismatch("result with nothing pending", 8'h00, got.data);
            return;
        end
        want = expected_tokens.pop_front();
        if (got.data !== want.data)
            log_mismatch("out_byte", want.data, got.data);
        if (got.has !== want.has)
            log_mismatch("has_byte", 8'(want.has), 8'(got.has));
        if (got.ce !== want.ce)
            log_mismatch("cell_end", 8'(want.ce), 8'(got.ce));
        if (got.le !== want.le)
            log_mismatch("line_end", 8'(want.le), 8'(got.le));
        if (got.last !== want.last)
            log_mismatch("run_last", 8'(want.last), 8'(got.last));
        if (got.ov !== want.ov)
            log_mismatch("space_overflow", 8'(want.ov), 8'(got.ov));
    endtask

    // Result side: random stall per result, payload taken mid-cycle.
    initial begin : result_sink
        t_token got;
        int     stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(negedge i_clk); while (out_ch.valid !== 1'b1);
            got.data = out_ch.out_byte;
            got.has = out_ch.has_byte;
            got.ce = out_ch.cell_end;
            got.le = out_ch.line_end;
            got.last = out_ch.run_last;
            got.ov = out_ch.space_overflow;
            @(posedge i_clk);
            check_token(got);
        end
    end

    // Stimulus: reset, directed table, then random lines per delimiter.
    initial begin : stimulus
        t_token     typed;
        logic [7:0] delim_plan [PHASES];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 8'h00;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_line = 1'b0;
        delim_plan = '{DELIM_RESET, 8'h00, 8'hFF, QUOTE_BYTE, WS_SPACE, WS_TAB, 8'h3B,
                       8'($urandom), DELIM_RESET};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            typed = '{data: plan[i].xb, has: plan[i].xh, ce: plan[i].xce,
                      le: plan[i].xle, last: 1'b1, ov: 1'b0};
            send_item(plan[i].b, plan[i].p, plan[i].e, plan[i].kind, typed);
        end

        // Buffer spill: flagged on the next visible byte, silent at cell end.
        send_item(8'h61, 1'b1, 1'b0);
        repeat (SPACE_DEPTH + 2) send_item(pick_blank(), 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(delim_q, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        repeat (SPACE_DEPTH + 1) send_item(pick_blank(), 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0)
                set_delimiter(delim_plan[phase]);
            while (items_sent < $size(plan) + (phase + 1) * PHASE_ITEMS) begin
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 6))
                        send_item(8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
                end else begin
                    send_line();
                end
            end
        end

        in_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (END_PAD) @(posedge i_clk);

        $display("tb_top: %0d requests under %0d delimiter settings, %0d results checked",
                 items_sent, delim_writes + 1, results_checked);
        $display("tb_top: %0d lines closed, %0d whitespace spill flags, %0d mismatches",
                 lines_closed, spill_flags, mismatches);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Run limit, several times the slowest legal run.
    initial begin : watchdog
        #4_000_000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ csv_field_splitter_top.f @@
+incdir+src
src/csvfs_pkg.sv
src/csvfs_if.sv
src/csvfs_front.sv
src/csvfs_queue.sv
src/csvfs_back.sv
src/csv_field_splitter_top.sv
src/csvfs_checker.sv
test/tb_top.sv
